FILE: src/rps_pkg.sv
package rps_pkg;

    localparam int PKT_LEN    = 9;
    localparam int IDX_W      = $clog2(PKT_LEN);

    localparam logic [7:0]  HDR_BYTE     = 8'hFF;
    localparam logic [7:0]  PKT_LENGTH   = 8'h05;
    localparam logic [7:0]  INSTR_WRITE  = 8'h03;

    localparam logic [15:0] PULSE_MIN    = 16'd1000;
    localparam logic [15:0] PULSE_MAX    = 16'd2000;
    localparam logic [10:0] PULSE_MID    = 11'd1500;
    localparam logic [15:0] MAG_MAX      = 16'h7FFF;

    localparam logic [7:0]  SERVO_ID_RST = 8'd1;
    localparam logic [7:0]  TARGET_RST   = 8'h2E;
    localparam logic [4:0]  SCALE_RST    = 5'd1;
    localparam logic [7:0]  DEADBAND_RST = 8'd50;

    // Configuration register indexes.
    localparam logic [2:0] REG_SERVO_ID = 3'd0;
    localparam logic [2:0] REG_TARGET   = 3'd1;
    localparam logic [2:0] REG_SCALE    = 3'd2;
    localparam logic [2:0] REG_DEADBAND = 3'd3;

    typedef logic [PKT_LEN-1:0][7:0] pkt_bytes_t;

    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] target_register;
        logic [4:0] speed_scale;
        logic [7:0] deadband;
    } cfg_t;

endpackage

FILE: src/rps_frame.sv
module rps_frame (
    input  logic [15:0]         pulse_width,
    input  rps_pkg::cfg_t       cfg,
    output rps_pkg::pkt_bytes_t pkt
);
    import rps_pkg::*;

    logic [10:0] clamped;
    logic        neg;
    logic [10:0] diff;
    logic [13:0] prod;
    logic [15:0] mag;
    logic [15:0] word;
    logic [10:0] sum;

    always_comb begin
        if (pulse_width >= PULSE_MAX) begin
            clamped = PULSE_MAX[10:0];
        end else if (pulse_width < PULSE_MIN) begin
            clamped = PULSE_MIN[10:0];
        end else begin
            clamped = pulse_width[10:0];
        end
        neg  = clamped < PULSE_MID;
        diff = neg ? (PULSE_MID - clamped) : (clamped - PULSE_MID);
        prod = diff[8:0] * cfg.speed_scale;
        mag  = {prod, 2'b00};
        // Inside the deadband the value is zero with a clear sign bit.
        if (mag <= {8'd0, cfg.deadband}) begin
            word = 16'd0;
        end else if (mag > MAG_MAX) begin
            word = {neg, MAG_MAX[14:0]};
        end else begin
            word = {neg, mag[14:0]};
        end

        sum = {3'd0, cfg.servo_id} + {3'd0, PKT_LENGTH} + {3'd0, INSTR_WRITE}
            + {3'd0, cfg.target_register} + {3'd0, word[7:0]} + {3'd0, word[15:8]};

        pkt[0] = HDR_BYTE;
        pkt[1] = HDR_BYTE;
        pkt[2] = cfg.servo_id;
        pkt[3] = PKT_LENGTH;
        pkt[4] = INSTR_WRITE;
        pkt[5] = cfg.target_register;
        pkt[6] = word[7:0];
        pkt[7] = word[15:8];
        pkt[8] = ~sum[7:0];
    end

endmodule

FILE: src/rps_tx.sv
module rps_tx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_valid,
    output logic                load_ready,
    input  rps_pkg::pkt_bytes_t load_pkt,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import rps_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

    pkt_bytes_t       pkt_reg;
    logic             vld_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             beat;
    logic             done;

    assign beat       = vld_reg && m_tready;
    assign done       = beat && (idx_reg == LAST_IDX);
    assign load_ready = !vld_reg || done;

    assign m_tvalid = vld_reg;
    assign m_tdata  = pkt_reg[idx_reg];
    assign m_tlast  = idx_reg == LAST_IDX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else if (load_valid && load_ready) begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end else if (done) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else if (beat) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            pkt_reg <= load_pkt;
        end
    end

endmodule

FILE: src/rc_pulse_to_servo_velocity_packet.sv
// Channel  Direction  tdata / data           tlast / other
// s_       in         [15:0] pulse_width     -
// m_       out        [7:0]  tx_byte         tlast = last_byte
// cfg_     in         cfg_index, cfg_data    cfg_ready always high
//
// A pulse beat is registered, then framed in one pass into the packet register.
// A changed pulse yields nine beats, one per cycle while m_tready is high; the byte
// serializer sets the sustained rate, and a repeated pulse yields no packet at all.
// The next pulse is taken while a packet is still being sent. Reset is synchronous,
// active low; configuration returns to its defaults and the stored pulse to zero.
// A stall on m_tready holds the current byte and backs up into s_tready.
module rc_pulse_to_servo_velocity_packet (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] pulse_width
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] tx_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rps_pkg::*;

    cfg_t        cfg_reg;
    logic        in_vld_reg;
    logic [15:0] pulse_reg;
    logic [15:0] prev_reg;
    logic        changed;
    logic        advance;
    logic        load_ready;
    pkt_bytes_t  pkt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.servo_id        <= SERVO_ID_RST;
            cfg_reg.target_register <= TARGET_RST;
            cfg_reg.speed_scale     <= SCALE_RST;
            cfg_reg.deadband        <= DEADBAND_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SERVO_ID: cfg_reg.servo_id        <= cfg_data;
                REG_TARGET:   cfg_reg.target_register <= cfg_data;
                REG_SCALE:    cfg_reg.speed_scale     <= cfg_data[4:0];
                REG_DEADBAND: cfg_reg.deadband        <= cfg_data;
                default: ;
            endcase
        end
    end

    // An unchanged pulse leaves the input register without producing a packet.
    assign changed  = pulse_reg != prev_reg;
    assign advance  = in_vld_reg && (!changed || load_ready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            prev_reg   <= 16'd0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance && changed) begin
                prev_reg <= pulse_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pulse_reg <= s_tdata;
        end
    end

    rps_frame u_frame (
        .pulse_width (pulse_reg),
        .cfg         (cfg_reg),
        .pkt         (pkt)
    );

    rps_tx u_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_vld_reg && changed),
        .load_ready (load_ready),
        .load_pkt   (pkt),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
